@@ src/sdc_pkg.sv @@
// shared constants, codes and controller/datapath interface types
// for the swipe direction classifier; no dependencies
package sdc_pkg;

   localparam int RING_DEPTH_DEF  = 20;
   localparam int DELTA_WIDTH_DEF = 16;

   localparam logic [15:0] WINDOW_RESET   = 16'd150;
   localparam logic [15:0] MIN_DIST_RESET = 16'd800;

   localparam logic [1:0] OP_BEGIN  = 2'd0;
   localparam logic [1:0] OP_UPDATE = 2'd1;
   localparam logic [1:0] OP_END    = 2'd2;

   localparam logic CSR_WINDOW   = 1'b0;
   localparam logic CSR_MIN_DIST = 1'b1;

   localparam logic [3:0] DIR_EAST  = 4'd0;
   localparam logic [3:0] DIR_NORTH = 4'd2;
   localparam logic [3:0] DIR_WEST  = 4'd4;
   localparam logic [3:0] DIR_SOUTH = 4'd6;
   localparam logic [3:0] DIR_NONE  = 4'd8;

   typedef struct packed {
      logic load;
      logic rd_en;
      logic mag_en;
      logic decide;
   } cmd_type;

   typedef struct packed {
      logic start_sum;
      logic rd_last;
      logic pipe_busy;
      logic done_ok;
   } status_type;

endpackage

@@ src/sdc_ctrl.sv @@
// sequencing state machine for the swipe direction classifier
// depends on sdc_pkg for the command and status types
module sdc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  sdc_pkg::status_type status,
   output sdc_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_FLUSH,
      ST_MAG,
      ST_DECIDE
   } state_type;

   state_type state_ff;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.rd_en  = (state_ff == ST_SUM);
      cmd.mag_en = (state_ff == ST_MAG);
      cmd.decide = (state_ff == ST_DECIDE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && status.start_sum) state_ff <= ST_SUM;
            end
            ST_SUM: begin
               if (status.rd_last) state_ff <= ST_FLUSH;
            end
            ST_FLUSH: begin
               if (!status.pipe_busy) state_ff <= ST_MAG;
            end
            ST_MAG: begin
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (status.done_ok) state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ src/sdc_dp.sv @@
// datapath of the swipe direction classifier: delta ring, windowed sums,
// direction decision, config registers and result register; uses sdc_pkg
module sdc_dp #(
   parameter int RING_DEPTH  = sdc_pkg::RING_DEPTH_DEF,
   parameter int DELTA_WIDTH = sdc_pkg::DELTA_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sdc_pkg::cmd_type       cmd,
   output sdc_pkg::status_type    status,
   input  logic [1:0]             opcode,
   input  logic [DELTA_WIDTH-1:0] delta_x,
   input  logic [DELTA_WIDTH-1:0] delta_y,
   input  logic [31:0]            event_time,
   input  logic [2:0]             touch_count,
   input  logic                   cancelled,
   input  logic                   csr_valid,
   input  logic                   csr_index,
   input  logic [15:0]            csr_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [2:0]             swipe_fingers,
   output logic [2:0]             swipe_direction
);

   localparam int AW    = $clog2(RING_DEPTH);
   localparam int ACC_W = DELTA_WIDTH + $clog2(RING_DEPTH);
   localparam int ENT_W = 2 * DELTA_WIDTH + 32;
   localparam int CMP_W = (ACC_W > 16) ? ACC_W : 16;
   localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

   logic [ENT_W-1:0]       ring_mem [RING_DEPTH];
   logic [RING_DEPTH-1:0]  valid_ff;
   logic [AW-1:0]          wp_ff;
   logic [AW-1:0]          rd_cnt_ff;
   logic [3:0]             dir_ff;
   logic [2:0]             fingers_ff;
   logic [15:0]            window_ff;
   logic [15:0]            min_dist_ff;
   logic [1:0]             op_ff;
   logic [31:0]            now_ff;

   logic [ENT_W-1:0]       rd_data_ff;
   logic                   rd_hit_ff;
   logic                   pa_ff;
   logic                   pb_ff;
   logic                   hit_ff;
   logic [DELTA_WIDTH-1:0] dxb_ff;
   logic [DELTA_WIDTH-1:0] dyb_ff;
   logic [ACC_W-1:0]       acc_x_ff;
   logic [ACC_W-1:0]       acc_y_ff;
   logic [ACC_W-1:0]       mag_x_ff;
   logic [ACC_W-1:0]       mag_y_ff;
   logic                   neg_x_ff;
   logic                   neg_y_ff;

   logic                   rsp_tvalid_ff;
   logic [2:0]             rsp_fingers_ff;
   logic [2:0]             rsp_dir_ff;

   logic [31:0]            age;
   logic [3:0]             dir_in;
   logic                   reach;
   logic                   out_free;
   logic                   out_load;

   // ring write and serial read
   always_ff @(posedge clock) begin
      if (cmd.load && opcode == sdc_pkg::OP_UPDATE) begin
         ring_mem[wp_ff] <= {event_time, delta_y, delta_x};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= ring_mem[rd_cnt_ff];
      end
   end

   assign age = now_ff - rd_data_ff[ENT_W-1 -: 32];

   always_comb begin
      if (mag_x_ff > mag_y_ff) begin
         dir_in = neg_x_ff ? sdc_pkg::DIR_WEST : sdc_pkg::DIR_EAST;
      end else begin
         dir_in = neg_y_ff ? sdc_pkg::DIR_NORTH : sdc_pkg::DIR_SOUTH;
      end
   end

   assign reach    = !((CMP_W'(mag_x_ff) < CMP_W'(min_dist_ff)) &&
                       (CMP_W'(mag_y_ff) < CMP_W'(min_dist_ff)));
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign out_load = cmd.decide && op_ff == sdc_pkg::OP_END && reach && out_free;

   always_comb begin
      status.start_sum = (opcode == sdc_pkg::OP_UPDATE) ||
                         (opcode == sdc_pkg::OP_END && !cancelled &&
                          dir_ff != sdc_pkg::DIR_NONE);
      status.rd_last   = (rd_cnt_ff == LAST_ADDR);
      status.pipe_busy = pa_ff || pb_ff;
      status.done_ok   = (op_ff != sdc_pkg::OP_END) || !reach || out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         wp_ff       <= '0;
         rd_cnt_ff   <= '0;
         dir_ff      <= sdc_pkg::DIR_NONE;
         fingers_ff  <= '0;
         window_ff   <= sdc_pkg::WINDOW_RESET;
         min_dist_ff <= sdc_pkg::MIN_DIST_RESET;
         pa_ff       <= 1'b0;
         pb_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               sdc_pkg::CSR_WINDOW:   window_ff   <= csr_data;
               sdc_pkg::CSR_MIN_DIST: min_dist_ff <= csr_data;
               default: ;
            endcase
         end

         if (cmd.load) begin
            rd_cnt_ff <= '0;
            if (opcode == sdc_pkg::OP_BEGIN) begin
               valid_ff   <= '0;
               wp_ff      <= '0;
               dir_ff     <= sdc_pkg::DIR_NONE;
               fingers_ff <= touch_count;
            end else if (opcode == sdc_pkg::OP_UPDATE) begin
               valid_ff[wp_ff] <= 1'b1;
               wp_ff <= (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
            end
         end else if (cmd.rd_en) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end

         pa_ff <= cmd.rd_en;
         pb_ff <= pa_ff;

         if (cmd.decide && op_ff == sdc_pkg::OP_UPDATE) begin
            dir_ff <= dir_in;
         end

         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= opcode;
         now_ff <= event_time;
      end
      if (cmd.rd_en) begin
         rd_hit_ff <= valid_ff[rd_cnt_ff];
      end
      hit_ff <= pa_ff && rd_hit_ff && (age <= 32'(window_ff));
      dxb_ff <= rd_data_ff[DELTA_WIDTH-1:0];
      dyb_ff <= rd_data_ff[2*DELTA_WIDTH-1 -: DELTA_WIDTH];
      if (cmd.load) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else if (pb_ff && hit_ff) begin
         acc_x_ff <= acc_x_ff + {{(ACC_W-DELTA_WIDTH){dxb_ff[DELTA_WIDTH-1]}}, dxb_ff};
         acc_y_ff <= acc_y_ff + {{(ACC_W-DELTA_WIDTH){dyb_ff[DELTA_WIDTH-1]}}, dyb_ff};
      end
      if (cmd.mag_en) begin
         neg_x_ff <= acc_x_ff[ACC_W-1];
         neg_y_ff <= acc_y_ff[ACC_W-1];
         mag_x_ff <= acc_x_ff[ACC_W-1] ? (~acc_x_ff + 1'b1) : acc_x_ff;
         mag_y_ff <= acc_y_ff[ACC_W-1] ? (~acc_y_ff + 1'b1) : acc_y_ff;
      end
      if (out_load) begin
         rsp_fingers_ff <= fingers_ff;
         rsp_dir_ff     <= dir_ff[2:0];
      end
   end

   assign rsp_tvalid      = rsp_tvalid_ff;
   assign swipe_fingers   = rsp_fingers_ff;
   assign swipe_direction = rsp_dir_ff;

`ifndef SYNTH
   a_out_from_end: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (op_ff == sdc_pkg::OP_END && dir_ff != sdc_pkg::DIR_NONE))
      else $error("result loaded without a directed end event");

   a_begin_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && opcode == sdc_pkg::OP_BEGIN) |=>
         (valid_ff == '0 && wp_ff == '0 && dir_ff == sdc_pkg::DIR_NONE))
      else $error("begin did not clear the ring");

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en || status.pipe_busy) |-> !cmd.load)
      else $error("item accepted during a ring walk");
`endif

endmodule

@@ src/swipe_direction_classifier.sv @@
// top level of the swipe direction classifier: stream ports, controller
// and datapath; depends on sdc_pkg, sdc_ctrl and sdc_dp
//
// Classifies touchpad swipes from begin, update and end events. A begin,
// an unused opcode, or an end that is cancelled or has no direction yet
// is finished in the idle state. An update or a live end walks the whole
// delta ring through its single read port, one entry per cycle, then drains
// the sum pipeline and resolves the sums. Updates set the current direction;
// a live end whose summed travel reaches min_distance on either axis returns
// one transfer with the finger count and direction. The result sits in an
// output register, so a new event is taken while it waits. Config writes are
// accepted in any cycle.
module swipe_direction_classifier #(
   parameter int RING_DEPTH  = sdc_pkg::RING_DEPTH_DEF,
   parameter int DELTA_WIDTH = sdc_pkg::DELTA_WIDTH_DEF,
   localparam int REQ_W = ((2 * DELTA_WIDTH + 36 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // delta_x, delta_y, event_time[31:0], touch_count[2:0], cancelled, zero pad
   input  logic [REQ_W-1:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // swipe_fingers[2:0], swipe_direction[2:0], zero pad
   output logic [7:0]       rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [15:0]      csr_data
);

   localparam int DW = DELTA_WIDTH;

   sdc_pkg::cmd_type    cmd;
   sdc_pkg::status_type status;
   logic [2:0]          swipe_fingers;
   logic [2:0]          swipe_direction;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {2'b00, swipe_direction, swipe_fingers};

   sdc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sdc_dp #(
      .RING_DEPTH  (RING_DEPTH),
      .DELTA_WIDTH (DELTA_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .opcode          (req_tuser),
      .delta_x         (req_tdata[DW-1:0]),
      .delta_y         (req_tdata[2*DW-1:DW]),
      .event_time      (req_tdata[2*DW+31:2*DW]),
      .touch_count     (req_tdata[2*DW+34:2*DW+32]),
      .cancelled       (req_tdata[2*DW+35]),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .swipe_fingers   (swipe_fingers),
      .swipe_direction (swipe_direction)
   );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench for swipe_direction_classifier: stream driver, result monitor
// and an in-bench swipe tracker that predicts each result; depends on sdc_pkg and the rtl
module tb_top;

   localparam int RING_SLOTS = sdc_pkg::RING_DEPTH_DEF;
   localparam int REQ_BITS   = ((2 * sdc_pkg::DELTA_WIDTH_DEF + 36 + 7) / 8) * 8;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic [31:0]        stamp;
      logic [2:0]         fingers;
      logic               cancel;
   } swipe_event_type;

   typedef struct packed {
      logic [2:0] fingers;
      logic [2:0] heading;
   } swipe_result_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic [1:0]          req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [7:0]          rsp_tdata;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = 1'b0;
   logic [15:0]         csr_data = '0;

   swipe_direction_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // swipe tracker state
   logic signed [15:0] ring_dx_m [RING_SLOTS];
   logic signed [15:0] ring_dy_m [RING_SLOTS];
   logic [31:0]        ring_t_m [RING_SLOTS];
   int unsigned        slot = 0;
   logic [3:0]         heading = sdc_pkg::DIR_NONE;
   logic [2:0]         fingers_held = '0;
   logic [15:0]        window_cfg = sdc_pkg::WINDOW_RESET;
   logic [15:0]        min_dist_cfg = sdc_pkg::MIN_DIST_RESET;

   swipe_event_type  pending_events[$];
   swipe_result_type expected_swipes[$];
   swipe_event_type  next_event;
   swipe_result_type want;
   int            issued_count = 0;
   int            accepted_count = 0;
   int            rsp_count = 0;
   int            rsp_seen = 0;
   int            send_gap = 0;
   int            send_calm = 0;
   int            rsp_stall = 0;
   int            rsp_calm = 0;
   int            error_count = 0;
   int            queued = 0;
   logic [31:0]   now_ms = 32'd5000;

   initial begin
      for (int i = 0; i < RING_SLOTS; i++) begin
         ring_dx_m[i] = '0;
         ring_dy_m[i] = '0;
         ring_t_m[i]  = '0;
      end
   end

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic void window_totals(input logic [31:0] now, output longint sx,
                                         output longint sy);
      logic [31:0] age;
      sx = 0;
      sy = 0;
      for (int i = 0; i < RING_SLOTS; i++) begin
         age = now - ring_t_m[i];
         if (age <= {16'd0, window_cfg}) begin
            sx += ring_dx_m[i];
            sy += ring_dy_m[i];
         end
      end
   endfunction

   function automatic logic [3:0] heading_of(input longint sx, input longint sy);
      if (magnitude(sx) > magnitude(sy))
         return (sx >= 0) ? sdc_pkg::DIR_EAST : sdc_pkg::DIR_WEST;
      return (sy >= 0) ? sdc_pkg::DIR_SOUTH : sdc_pkg::DIR_NORTH;
   endfunction

   function automatic void track_swipe(input logic [1:0] op, input logic [REQ_BITS-1:0] data);
      longint           sx, sy;
      logic [31:0]      now;
      swipe_result_type res;
      now = data[63:32];
      case (op)
         sdc_pkg::OP_BEGIN: begin
            for (int i = 0; i < RING_SLOTS; i++) begin
               ring_dx_m[i] = '0;
               ring_dy_m[i] = '0;
               ring_t_m[i]  = '0;
            end
            slot = 0;
            heading = sdc_pkg::DIR_NONE;
            fingers_held = data[66:64];
         end
         sdc_pkg::OP_UPDATE: begin
            ring_dx_m[slot] = data[15:0];
            ring_dy_m[slot] = data[31:16];
            ring_t_m[slot]  = now;
            slot = (slot + 1) % RING_SLOTS;
            window_totals(now, sx, sy);
            heading = heading_of(sx, sy);
         end
         sdc_pkg::OP_END: begin
            if (!data[67] && heading < sdc_pkg::DIR_NONE) begin
               window_totals(now, sx, sy);
               if (magnitude(sx) >= longint'(min_dist_cfg) ||
                   magnitude(sy) >= longint'(min_dist_cfg)) begin
                  res.fingers = fingers_held;
                  res.heading = heading[2:0];
                  expected_swipes.push_back(res);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   // event driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && accepted_count != issued_count) begin
         // transfer still pending
      end else if (send_gap > 0) begin
         req_tvalid <= 1'b0;
         send_gap--;
      end else if (pending_events.size() != 0) begin
         next_event = pending_events.pop_front();
         req_tuser  <= next_event.opcode;
         req_tdata  <= {{(REQ_BITS - 68){1'b0}}, next_event.cancel, next_event.fingers,
                        next_event.stamp, next_event.dy, next_event.dx};
         req_tvalid <= 1'b1;
         issued_count++;
         send_gap = draw_wait(send_calm);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result receiver with random stalls
   always @(negedge clock) begin
      if (rsp_count != rsp_seen) begin
         rsp_seen = rsp_count;
         rsp_stall = draw_wait(rsp_calm);
      end
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: check results, then track accepted events
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (expected_swipes.size() == 0) begin
               $display("%0t: unexpected result, expected none, got fingers %0d direction %0d",
                        $time, rsp_tdata[2:0], rsp_tdata[5:3]);
               error_count++;
            end else begin
               want = expected_swipes.pop_front();
               if (rsp_tdata[2:0] != want.fingers) begin
                  $display("%0t: swipe_fingers expected %0d got %0d",
                           $time, want.fingers, rsp_tdata[2:0]);
                  error_count++;
               end
               if (rsp_tdata[5:3] != want.heading) begin
                  $display("%0t: swipe_direction expected %0d got %0d",
                           $time, want.heading, rsp_tdata[5:3]);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            accepted_count++;
            track_swipe(req_tuser, req_tdata);
         end
      end
   end

   function automatic swipe_event_type make_event(input logic [1:0] op, input int dx,
                                                  input int dy, input logic [31:0] stamp,
                                                  input int fingers, input int cancel);
      swipe_event_type ev;
      ev.opcode  = op;
      ev.dx      = 16'(dx);
      ev.dy      = 16'(dy);
      ev.stamp   = stamp;
      ev.fingers = 3'(fingers);
      ev.cancel  = 1'(cancel);
      return ev;
   endfunction

   function automatic int clamp_delta(input int v);
      if (v > 32767)
         return 32767;
      if (v < -32768)
         return -32768;
      return v;
   endfunction

   task automatic push_event(input swipe_event_type ev);
      pending_events.push_back(ev);
      if (ev.opcode != OP_UNUSED)
         queued++;
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      if (idx == sdc_pkg::CSR_WINDOW)
         window_cfg = value;
      else
         min_dist_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do
         @(posedge clock);
      while (pending_events.size() != 0 || accepted_count != issued_count ||
             expected_swipes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // begin, a run of updates and an end, with occasional broken pieces
   task automatic queue_gesture();
      int span, bx, by, updates, mode;
      if ($urandom_range(0, 9) == 0)
         now_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
      else
         now_ms += $urandom_range(1, 2000);
      mode = $urandom_range(0, 3);
      span = (mode == 0) ? 150 : (mode == 1) ? 1500 : (mode == 2) ? 8000 : 32768;
      bx = int'($urandom_range(0, span)) - span / 2;
      by = int'($urandom_range(0, span)) - span / 2;
      updates = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      if ($urandom_range(0, 9) != 0)
         push_event(make_event(sdc_pkg::OP_BEGIN, $urandom(), $urandom(), now_ms,
                               $urandom_range(0, 7), $urandom_range(0, 1)));
      for (int i = 0; i < updates; i++) begin
         now_ms += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         push_event(make_event(sdc_pkg::OP_UPDATE,
                               clamp_delta(bx + int'($urandom_range(0, 2 * span)) - span),
                               clamp_delta(by + int'($urandom_range(0, 2 * span)) - span),
                               now_ms, $urandom_range(0, 7), $urandom_range(0, 1)));
      end
      now_ms += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 60);
      push_event(make_event(sdc_pkg::OP_END, $urandom(), $urandom(), now_ms,
                            $urandom_range(0, 7), ($urandom_range(0, 7) == 0)));
      if ($urandom_range(0, 7) == 0)
         push_event(make_event(sdc_pkg::OP_END, $urandom(), $urandom(),
                               now_ms + $urandom_range(0, 30), $urandom_range(0, 7), 0));
   endtask

   task automatic queue_noise();
      logic [31:0] stamp;
      stamp = ($urandom_range(0, 1) == 1) ? $urandom() : now_ms + $urandom_range(0, 100);
      push_event(make_event(2'($urandom_range(0, 3)), int'($urandom_range(0, 65535)) - 32768,
                            int'($urandom_range(0, 65535)) - 32768, stamp,
                            $urandom_range(0, 7), $urandom_range(0, 1)));
   endtask

   task automatic run_phase(input logic [15:0] window, input logic [15:0] min_dist,
                            input int target);
      write_csr(sdc_pkg::CSR_WINDOW, window);
      write_csr(sdc_pkg::CSR_MIN_DIST, min_dist);
      queued = 0;
      while (queued < target) begin
         if ($urandom_range(0, 5) == 0)
            queue_noise();
         else
            queue_gesture();
      end
      wait_idle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: end with no direction, unused opcode, update without begin,
      // repeated end, equal magnitudes, cancel, window edge, short travel, time wrap
      push_event(make_event(sdc_pkg::OP_END, 0, 0, 32'd5, 0, 0));
      push_event(make_event(OP_UNUSED, -1, -1, 32'hFFFF_FFFF, 7, 1));
      push_event(make_event(sdc_pkg::OP_UPDATE, 32767, 0, 32'd10, 0, 0));
      push_event(make_event(sdc_pkg::OP_END, 0, 0, 32'd10, 0, 0));
      push_event(make_event(sdc_pkg::OP_END, 0, 0, 32'd10, 0, 0));
      push_event(make_event(sdc_pkg::OP_BEGIN, 0, 0, 32'd20, 7, 0));
      push_event(make_event(sdc_pkg::OP_UPDATE, -32768, -32768, 32'd30, 0, 0));
      push_event(make_event(sdc_pkg::OP_UPDATE, 0, 32767, 32'd40, 0, 0));
      push_event(make_event(sdc_pkg::OP_END, 0, 0, 32'd40, 0, 1));
      push_event(make_event(sdc_pkg::OP_END, 0, 0, 32'd40, 0, 0));
      push_event(make_event(sdc_pkg::OP_END, 0, 0, 32'd191, 0, 0));
      push_event(make_event(sdc_pkg::OP_BEGIN, 0, 0, 32'd300, 3, 0));
      push_event(make_event(sdc_pkg::OP_UPDATE, 100, -50, 32'd300, 0, 0));
      push_event(make_event(sdc_pkg::OP_END, 0, 0, 32'd300, 0, 0));
      push_event(make_event(sdc_pkg::OP_BEGIN, 0, 0, 32'd1000, 5, 0));
      push_event(make_event(sdc_pkg::OP_UPDATE, -10, 900, 32'd1000, 0, 0));
      push_event(make_event(sdc_pkg::OP_END, 0, 0, 32'd1150, 0, 0));
      push_event(make_event(sdc_pkg::OP_END, 0, 0, 32'd1151, 0, 0));
      push_event(make_event(sdc_pkg::OP_BEGIN, 0, 0, 32'hFFFF_FFF0, 2, 0));
      push_event(make_event(sdc_pkg::OP_UPDATE, 0, -900, 32'hFFFF_FFF0, 0, 0));
      push_event(make_event(sdc_pkg::OP_END, 0, 0, 32'h0000_0040, 0, 0));
      push_event(make_event(sdc_pkg::OP_BEGIN, 0, 0, 32'h0000_0050, 0, 0));
      push_event(make_event(sdc_pkg::OP_END, 0, 0, 32'h0000_0050, 0, 0));
      wait_idle();

      run_phase(16'd150, 16'd800, 250);
      run_phase(16'd0, 16'd0, 250);
      run_phase(16'd65535, 16'd65535, 250);
      run_phase(16'($urandom_range(1, 400)), 16'($urandom_range(1, 3000)), 250);
      run_phase(16'd50, 16'd20, 250);
      run_phase(16'd65535, 16'd0, 250);
      run_phase(16'd150, 16'd800, 250);

      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ swipe_direction_classifier.f @@
src/sdc_pkg.sv
src/sdc_ctrl.sv
src/sdc_dp.sv
src/swipe_direction_classifier.sv
dv/tb_top.sv
